// ===== design/dfq_pkg.sv =====
// dfq_pkg: shared types and constants for the duplicate-filtering fifo queue
// used by dfq_cell, dedup_fifo_queue and dfq_checker; no dependencies
package dfq_pkg;

    // fixed field widths of the stream words
    localparam int MODE_W        = 2;
    localparam int IN_ID_W       = 64;
    localparam int STATUS_W      = 3;
    localparam int COUNT_FIELD_W = 5;
    localparam int OUT_TDATA_W   = 72;
    localparam int OUT_TUSER_W   = 4;

    // request kinds; code 3 is unused
    localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_GET   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_DISABLED  = 3'd1,
        STAT_DUPLICATE = 3'd2,
        STAT_NULL_ID   = 3'd3,
        STAT_EMPTY     = 3'd4,
        STAT_FULL      = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_DONE
    } state_t;

    // per-cell control from the queue controller
    typedef struct packed {
        logic load;
        logic shift;
        logic occupied;
    } cell_ctrl_t;

    // search token handed from cell to cell
    typedef struct packed {
        logic token;
        logic match;
    } chain_t;

endpackage

// ===== design/dfq_cell.sv =====
// dfq_cell: one queue slot holding an identifier, plus one stage of the
// duplicate-search chain; depends on dfq_pkg
module dfq_cell
    import dfq_pkg::*;
#(
    parameter int ID_WIDTH = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cell_ctrl_t          ctrl,
    input  logic [ID_WIDTH-1:0] new_id,
    input  logic [ID_WIDTH-1:0] next_id,
    input  logic [ID_WIDTH-1:0] query_id,
    input  chain_t              chain_in,
    output chain_t              chain_out,
    output logic [ID_WIDTH-1:0] id_out
);

    logic [ID_WIDTH-1:0] id_reg;
    logic                token_reg;
    logic                match_reg;
    logic                match_next;

    // slot payload: written on add, takes the neighbor's word on pop
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            id_reg <= new_id;
        end else if (ctrl.shift) begin
            id_reg <= next_id;
        end
    end

    assign match_next = chain_in.match
                      | (chain_in.token & ctrl.occupied & (id_reg == query_id));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            token_reg <= 1'b0;
            match_reg <= 1'b0;
        end else begin
            token_reg <= chain_in.token;
            match_reg <= match_next;
        end
    end

    assign chain_out = '{token: token_reg, match: match_reg};
    assign id_out    = id_reg;

endmodule

// ===== design/dedup_fifo_queue.sv =====
// dedup_fifo_queue: fifo of identifiers that refuses duplicates
// top level: request controller, a row of dfq_cell slots; depends on dfq_pkg
//
// channel  direction  fields (low bit up)
// s_axis   in         tuser: mode[1:0]  tdata: object_id[63:0]
// m_axis   out        tuser: ok[0], status[3:1]
//                     tdata: popped_id[63:0], entry_count[68:64], zero pad
// cfg_w    in         wdata: pool_enable
//
// one request at a time. an add that passes the null and enable checks sends
// a token down the row of DEPTH cells, one cell a cycle, before its result is
// formed; get, clear and adds refused by those checks skip the search.
// a finished word waits in the output register while the next one is taken;
// a stalled output holds the controller in its result state.
// reset clears state, count, enable and the search chain; slot contents are not
// cleared and only occupied slots are ever read.
module dedup_fifo_queue
    import dfq_pkg::*;
#(
    parameter int DEPTH    = 16,
    parameter int ID_WIDTH = 64
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_ID_W-1:0]     s_axis_tdata,   // object_id
    input  logic [MODE_W-1:0]      s_axis_tuser,   // mode
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // popped_id, entry_count
    output logic [OUT_TUSER_W-1:0] m_axis_tuser,   // ok, status
    input  logic                   cfg_wvalid,
    output logic                   cfg_wready,
    input  logic                   cfg_wdata       // pool_enable
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    state_t                     state_reg, state_next;
    logic [MODE_W-1:0]          req_mode_reg;
    logic [ID_WIDTH-1:0]        req_id_reg;
    logic                       start_reg;
    logic                       dup_reg;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic                       enable_reg;

    logic                       m_valid_reg;
    logic                       out_ok_reg;
    status_t                    out_status_reg;
    logic [IN_ID_W-1:0]         out_popped_reg;
    logic [COUNT_FIELD_W-1:0]   out_count_reg;

    logic                       s_accept;
    logic                       needs_search;
    logic                       out_free;
    logic                       fire;
    logic                       res_ok;
    status_t                    res_status;
    logic [IN_ID_W-1:0]         res_popped;
    logic                       do_add, do_get, do_clear;

    logic [ID_WIDTH-1:0]        cell_id [DEPTH];
    chain_t                     chain   [DEPTH+1];
    cell_ctrl_t                 ctrl    [DEPTH];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_accept      = s_axis_tvalid & s_axis_tready;
    assign needs_search  = (s_axis_tuser == MODE_ADD)
                         & (s_axis_tdata[ID_WIDTH-1:0] != '0) & enable_reg;
    assign out_free      = ~m_valid_reg | m_axis_tready;
    assign fire          = (state_reg == S_DONE) & out_free;
    assign cfg_wready    = 1'b1;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    state_next = needs_search ? S_SEARCH : S_DONE;
                end
            end
            S_SEARCH: begin
                if (chain[DEPTH].token) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // request outcome, checks in priority order
    always_comb begin
        res_ok     = 1'b0;
        res_status = STAT_DISABLED;
        res_popped = '0;
        do_add     = 1'b0;
        do_get     = 1'b0;
        do_clear   = 1'b0;
        unique case (req_mode_reg)
            MODE_ADD: begin
                priority if (req_id_reg == '0) begin
                    res_status = STAT_NULL_ID;
                end else if (!enable_reg) begin
                    res_status = STAT_DISABLED;
                end else if (dup_reg) begin
                    res_status = STAT_DUPLICATE;
                end else if (count_reg == CNT_W'(DEPTH)) begin
                    res_status = STAT_FULL;
                end else begin
                    res_ok     = 1'b1;
                    res_status = STAT_OK;
                    do_add     = 1'b1;
                end
            end
            MODE_GET: begin
                priority if (!enable_reg) begin
                    res_status = STAT_DISABLED;
                end else if (count_reg == '0) begin
                    res_status = STAT_EMPTY;
                end else begin
                    res_ok     = 1'b1;
                    res_status = STAT_OK;
                    res_popped = IN_ID_W'(cell_id[0]);
                    do_get     = 1'b1;
                end
            end
            MODE_CLEAR: begin
                res_ok     = 1'b1;
                res_status = STAT_OK;
                do_clear   = 1'b1;
            end
            default: begin
                res_status = STAT_DISABLED;
            end
        endcase
    end

    always_comb begin
        priority if (do_clear) begin
            count_next = '0;
        end else if (do_add) begin
            count_next = CNT_W'(count_reg + 1'b1);
        end else if (do_get) begin
            count_next = CNT_W'(count_reg - 1'b1);
        end else begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            start_reg   <= 1'b0;
            count_reg   <= '0;
            enable_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            start_reg <= s_accept & needs_search;
            if (cfg_wvalid) begin
                enable_reg <= cfg_wdata;
            end
            if (fire) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            req_mode_reg <= s_axis_tuser;
            req_id_reg   <= s_axis_tdata[ID_WIDTH-1:0];
            dup_reg      <= 1'b0;
        end else if (chain[DEPTH].token) begin
            dup_reg <= chain[DEPTH].match;
        end
        if (fire) begin
            out_ok_reg     <= res_ok;
            out_status_reg <= res_status;
            out_popped_reg <= res_popped;
            out_count_reg  <= COUNT_FIELD_W'(count_next);
        end
    end

    assign chain[0] = '{token: start_reg, match: 1'b0};

    // row of slots, oldest in cell 0
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [ID_WIDTH-1:0] nbr_id;

        if (i < DEPTH - 1) begin : g_mid
            assign nbr_id = cell_id[i+1];
        end else begin : g_last
            assign nbr_id = cell_id[i];
        end

        assign ctrl[i] = '{
            load:     fire & do_add & (count_reg == CNT_W'(i)),
            shift:    fire & do_get,
            occupied: (CNT_W'(i) < count_reg)
        };

        dfq_cell #(
            .ID_WIDTH(ID_WIDTH)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl[i]),
            .new_id    (req_id_reg),
            .next_id   (nbr_id),
            .query_id  (req_id_reg),
            .chain_in  (chain[i]),
            .chain_out (chain[i+1]),
            .id_out    (cell_id[i])
        );
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W - IN_ID_W - COUNT_FIELD_W)'(0),
                            out_count_reg, out_popped_reg};
    assign m_axis_tuser  = {out_status_reg, out_ok_reg};

endmodule

// ===== design/dfq_checker.sv =====
// dfq_checker: port-level checks on the result stream of dedup_fifo_queue
// bound to the top level below; depends on dfq_pkg
module dfq_checker
    import dfq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [OUT_TUSER_W-1:0] m_axis_tuser
);

    // ok set exactly when status is success
    a_ok_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tuser[0] == (m_axis_tuser[3:1] == STAT_OK)))
        else $error("ok and status disagree");

    // a failed request never reports a popped identifier
    a_pop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[63:0] == '0))
        else $error("popped id on failed request");

    // empty reports a zero count, full reports the whole depth
    a_empty_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser[3:1] == STAT_EMPTY)
            |-> (m_axis_tdata[68:64] == '0))
        else $error("empty with nonzero count");

    a_full_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser[3:1] == STAT_FULL)
            |-> (m_axis_tdata[68:64] == COUNT_FIELD_W'(DEPTH)))
        else $error("full with wrong count");

    // stalled word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready)
            |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("result word changed under stall");

endmodule

bind dedup_fifo_queue dfq_checker #(
    .DEPTH(DEPTH)
) u_dfq_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
